// ===== hdl/scalar_minmax_quantizer_core_defines.svh =====
// scalar_minmax_quantizer_core_defines.svh: assertion macros for the quantizer core
// used by files that assert; expects i_clk and i_rst_n in the including module
`ifndef SCALAR_MINMAX_QUANTIZER_CORE_DEFINES_SVH
`define SCALAR_MINMAX_QUANTIZER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define SMMQ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SMMQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smmq_pkg.sv =====
// smmq_pkg: widths, request codes, shared structs and the level helper
// for the min/max scalar quantizer; no dependencies
package smmq_pkg;

    // field widths
    localparam int VALUE_W = 16;
    localparam int CODE_W  = 8;
    localparam int CFG_W   = 4;
    localparam int REQ_W   = 2;

    // datapath widths
    localparam int DIFF_W = VALUE_W;
    localparam int PROD_W = DIFF_W + CODE_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DEN_W  = DIFF_W + 1;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    localparam logic [CFG_W-1:0] CODE_BITS_RST = CFG_W'(CODE_W);

    // request codes
    localparam logic [REQ_W-1:0] REQ_TRAIN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENC   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEC   = 2'd2;

    // train update toward the range tracker
    typedef struct packed {
        logic                      upd;
        logic                      first;
        logic signed [VALUE_W-1:0] x;
    } t_train;

    // tracker status
    typedef struct packed {
        logic signed [VALUE_W-1:0] min_v;
        logic signed [VALUE_W-1:0] max_v;
        logic                      has;
        logic                      empty;
        logic [DIFF_W-1:0]         span;
    } t_range;

    // divider request
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    // largest code for a code width, width clamped to 1..CODE_W
    function automatic logic [CODE_W-1:0] level_max(input logic [CFG_W-1:0] bits);
        logic [CFG_W-1:0]  b;
        logic [CODE_W-1:0] lv;
        b = bits;
        if (b == '0) begin
            b = CFG_W'(1);
        end else if (b > CFG_W'(CODE_W)) begin
            b = CFG_W'(CODE_W);
        end
        for (int i = 0; i < CODE_W; i++) begin
            lv[i] = (CFG_W'(i) < b);
        end
        return lv;
    endfunction

endpackage

// ===== hdl/smmq_req_if.sv =====
// smmq_req_if: request channel of the quantizer, valid/ready with payload
// depends on smmq_pkg
interface smmq_req_if;
    import smmq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      first_of_set;
    logic [CODE_W-1:0]         code_in;

    modport source (output valid, req_type, sample_value, first_of_set, code_in,
                    input ready);
    modport sink   (input valid, req_type, sample_value, first_of_set, code_in,
                    output ready);
endinterface

// ===== hdl/smmq_res_if.sv =====
// smmq_res_if: result channel of the quantizer, valid/ready with payload
// depends on smmq_pkg
interface smmq_res_if;
    import smmq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CODE_W-1:0]         code_out;
    logic signed [VALUE_W-1:0] value_out;
    logic                      range_empty;

    modport source (output valid, code_out, value_out, range_empty, input ready);
    modport sink   (input valid, code_out, value_out, range_empty, output ready);
endinterface

// ===== hdl/smmq_div.sv =====
// smmq_div: restoring serial divider, one quotient bit per cycle
// depends on smmq_pkg
module smmq_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smmq_pkg::t_div_req             i_div,
    output logic                           o_done,
    output logic [smmq_pkg::NUM_W-1:0]     o_quot
);
    import smmq_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_acc;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_sub;
    logic             w_fit;
    logic [DEN_W-1:0] n_rem;
    logic [NUM_W-1:0] n_acc;

    // one trial subtraction per cycle
    always_comb begin
        w_trial = {r_rem, r_acc[NUM_W-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
        w_sub   = w_trial - {1'b0, r_den};
        n_rem   = w_fit ? w_sub[DEN_W-1:0] : w_trial[DEN_W-1:0];
        n_acc   = {r_acc[NUM_W-2:0], w_fit};
    end

    // control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_div.start && (r_cnt == CNT_W'(1));
            if (i_div.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: numerator shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_div.start) begin
            r_acc <= i_div.num;
            r_den <= i_div.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

// ===== hdl/smmq_range.sv =====
// smmq_range: running minimum and maximum of trained samples, range status
// depends on smmq_pkg and the assertion macro header
`include "scalar_minmax_quantizer_core_defines.svh"

module smmq_range (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smmq_pkg::t_train  i_train,
    output smmq_pkg::t_range  o_rng
);
    import smmq_pkg::*;

    logic signed [VALUE_W-1:0] r_min;
    logic signed [VALUE_W-1:0] r_max;
    logic                      r_has;

    logic signed [VALUE_W:0]   w_diff;
    logic                      w_empty;

    // range status
    always_comb begin
        w_diff  = {r_max[VALUE_W-1], r_max} - {r_min[VALUE_W-1], r_min};
        w_empty = !r_has || (r_max <= r_min);
        o_rng.min_v = r_min;
        o_rng.max_v = r_max;
        o_rng.has   = r_has;
        o_rng.empty = w_empty;
        o_rng.span  = w_empty ? '0 : w_diff[DIFF_W-1:0];
    end

    // tracking, restart on first item of a set or when no sample is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= {1'b0, {(VALUE_W-1){1'b1}}};
            r_max <= {1'b1, {(VALUE_W-1){1'b0}}};
            r_has <= 1'b0;
        end else if (i_train.upd) begin
            r_has <= 1'b1;
            if (i_train.first || !r_has) begin
                r_min <= i_train.x;
                r_max <= i_train.x;
            end else begin
                if (i_train.x < r_min) begin
                    r_min <= i_train.x;
                end
                if (i_train.x > r_max) begin
                    r_max <= i_train.x;
                end
            end
        end
    end

    `SMMQ_ASSERT_IMPL(a_min_le_max, r_has, r_min <= r_max, "min above max with samples")
    `SMMQ_ASSERT_NEXT(a_has_after_train, i_train.upd, r_has, "train did not set samples")
    `SMMQ_ASSERT_NEXT(a_restart, i_train.upd && i_train.first, r_min == r_max,
        "restart did not collapse range")

endmodule

// ===== hdl/scalar_minmax_quantizer_core.sv =====
// scalar_minmax_quantizer_core: top level of the min/max scalar quantizer
// depends on smmq_pkg, smmq_req_if, smmq_res_if, smmq_range, smmq_div, macro header
//
// channel     dir  handshake      payload
// i_req       in   valid/ready    req_type, sample_value, first_of_set, code_in
// o_res       out  valid/ready    code_out, value_out, range_empty
// i_cfg_*     in   write enable   code_bits
//
// train items leave the core idle; encode and decode go from accept to the output
// register through multiply, add, divider load, 25 divider steps, capture and finish;
// encode of an empty range or a value at or below min, and decode of an empty range, go
// from multiply straight to finish; no new item is accepted until the core is back in idle
// reset is synchronous and active low; min/max return to their extremes
// a result waits in the output register while the next item is accepted; a second result
// holds the core in its finish step until the first one is taken

`include "scalar_minmax_quantizer_core_defines.svh"

module scalar_minmax_quantizer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [smmq_pkg::CFG_W-1:0]  i_cfg_wdata,
    smmq_req_if.sink                    i_req,
    smmq_res_if.source                  o_res
);
    import smmq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_FIN
    } t_state;

    t_state                    r_state;
    logic [CFG_W-1:0]          r_code_bits;
    logic                      r_enc;
    logic signed [VALUE_W-1:0] r_x;
    logic [CODE_W-1:0]         r_code;
    logic [CODE_W-1:0]         r_lv;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_div_start;
    logic [CODE_W-1:0]         r_res_code;
    logic signed [VALUE_W-1:0] r_res_val;
    logic                      r_res_empty;
    logic                      r_out_valid;
    logic [CODE_W-1:0]         r_out_code;
    logic signed [VALUE_W-1:0] r_out_val;
    logic                      r_out_empty;

    logic                      w_in_acc;
    logic                      w_is_calc;
    logic [CODE_W-1:0]         w_lv_now;
    t_train                    w_train;
    t_range                    w_rng;
    logic signed [VALUE_W:0]   w_diff;
    logic                      w_above;
    logic [DIFF_W-1:0]         w_mul_a;
    logic [CODE_W-1:0]         w_mul_b;
    logic [PROD_W-1:0]         w_prod;
    logic [DIFF_W-1:0]         w_bias;
    t_div_req                  w_div;
    logic                      w_div_done;
    logic [NUM_W-1:0]          w_quot;
    logic [CODE_W-1:0]         w_enc_code;
    logic [VALUE_W-1:0]        w_dec_val;

    // input handshake and train path
    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_is_calc   = (i_req.req_type == REQ_ENC) || (i_req.req_type == REQ_DEC);
    assign w_lv_now    = level_max(r_code_bits);

    always_comb begin
        w_train.upd   = w_in_acc && (i_req.req_type == REQ_TRAIN);
        w_train.first = i_req.first_of_set;
        w_train.x     = i_req.sample_value;
    end

    smmq_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_train (w_train),
        .o_rng   (w_rng)
    );

    // offset from min, and the shared multiplier operands
    always_comb begin
        w_diff  = {r_x[VALUE_W-1], r_x} - {w_rng.min_v[VALUE_W-1], w_rng.min_v};
        w_above = !w_diff[VALUE_W] && (w_diff != '0);
        w_mul_a = r_enc ? w_diff[DIFF_W-1:0] : w_rng.span;
        w_mul_b = r_enc ? r_lv : r_code;
        w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    end

    // rounded division: (2*p + half divisor) / divisor
    always_comb begin
        w_bias    = r_enc ? w_rng.span : DIFF_W'(r_lv);
        w_div.start = r_div_start;
        w_div.num   = {r_prod, 1'b0} + NUM_W'(w_bias);
        w_div.den   = r_enc ? {w_rng.span, 1'b0} : {DIFF_W'(r_lv), 1'b0};
    end

    smmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (w_div),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // clamp code to the top level, rebuild value from min
    always_comb begin
        w_enc_code = (w_quot > NUM_W'(r_lv)) ? r_lv : w_quot[CODE_W-1:0];
        w_dec_val  = w_rng.min_v + w_quot[VALUE_W-1:0];
    end

    // sequencer, config register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code_bits <= CODE_BITS_RST;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_ADD);
            if (i_cfg_we) begin
                r_code_bits <= i_cfg_wdata;
            end
            if (o_res.valid && o_res.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && w_is_calc) begin
                        r_enc   <= (i_req.req_type == REQ_ENC);
                        r_x     <= i_req.sample_value;
                        r_lv    <= w_lv_now;
                        r_code  <= (i_req.code_in > w_lv_now) ? w_lv_now : i_req.code_in;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_enc && (w_rng.empty || !w_above)) begin
                        r_res_code  <= '0;
                        r_res_val   <= '0;
                        r_res_empty <= w_rng.empty;
                        r_state     <= S_FIN;
                    end else if (!r_enc && w_rng.empty) begin
                        r_res_code  <= '0;
                        r_res_val   <= w_rng.has ? w_rng.min_v : '0;
                        r_res_empty <= 1'b1;
                        r_state     <= S_FIN;
                    end else begin
                        r_prod  <= w_prod;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res_code  <= r_enc ? w_enc_code : '0;
                        r_res_val   <= r_enc ? '0 : w_dec_val;
                        r_res_empty <= 1'b0;
                        r_state     <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_code  <= r_res_code;
                        r_out_val   <= r_res_val;
                        r_out_empty <= r_res_empty;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.code_out    = r_out_code;
    assign o_res.value_out   = r_out_val;
    assign o_res.range_empty = r_out_empty;

    `SMMQ_ASSERT_NEXT(a_busy_after_accept, w_in_acc && w_is_calc, !i_req.ready,
        "ready while an item is in work")
    `SMMQ_ASSERT_IMPL(a_done_in_div, w_div_done, r_state == S_DIV,
        "divider finished outside the divide step")
    `SMMQ_ASSERT_IMPL(a_empty_zero_code, r_out_valid && r_out_empty, r_out_code == '0,
        "nonzero code with empty range")
    `SMMQ_ASSERT_IMPL(a_code_in_levels, r_out_valid, r_out_code <= level_max(r_code_bits),
        "code above the top level")

endmodule
